/* src/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority run queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int NUM_LEVELS = 16;
    localparam int NUM_TASKS  = 64;
    localparam int NUM_CORES  = 4;
    localparam int TID_W      = 6;
    localparam int LVL_W      = 4;
    localparam int CORE_W     = 2;
    localparam int CNT_W      = 7;
    localparam logic [15:0] MOVE_DELAY_RESET = 16'd10;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_PICK = 2'd1,
        OP_STOP = 2'd2,
        OP_PRE  = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LVL,
        ST_RD,
        ST_EVAL,
        ST_UNLINK,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_TAKE,
        ST_DONE
    } state_t;

endpackage

/* src/prq_if.sv */
// ----------------------------------------------------------------------------
// prq_in_if / prq_out_if / prq_cfg_if
// Valid/ready channels of the run queue.
// ----------------------------------------------------------------------------
interface prq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [5:0]  task_id;
    logic [3:0]  priority_req;
    logic        wired_valid;
    logic [1:0]  wired_core;
    logic [1:0]  core_id;
    logic [31:0] now_ticks;
    logic        tick_event;
    logic        stop_value;
    modport source (output valid, opcode, task_id, priority_req, wired_valid, wired_core,
                    core_id, now_ticks, tick_event, stop_value, input ready);
    modport sink (input valid, opcode, task_id, priority_req, wired_valid, wired_core,
                  core_id, now_ticks, tick_event, stop_value, output ready);
endinterface

interface prq_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [5:0]  chosen_task;
    logic        preempt;
    logic [6:0]  ready_total;
    logic [15:0] level_bitmap;
    modport source (output valid, found, chosen_task, preempt, ready_total, level_bitmap,
                    input ready);
    modport sink (input valid, found, chosen_task, preempt, ready_total, level_bitmap,
                  output ready);
endinterface

interface prq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* src/priority_run_queue_with_affinity_unit.sv */
// ----------------------------------------------------------------------------
// priority_run_queue_with_affinity_unit
// Multilevel ready queue with per-core affinity, walked by a sequencer.
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_ch   | in  | opcode, task, level, wiring, core, ticks, tick, stop
// out_ch  | out | found, chosen task, preempt, ready total, level bitmap
// cfg_ch  | in  | move_delay
// Enqueue, set-stop, preempt: the word goes from idle through the done state,
// which registers the result. Pick: the sequencer walks one queue entry per
// read and evaluate step, two passes per level; each stopped task that is
// dropped rescans its level.
// Reset clears control, bitmap, count, queued/stop/last-valid bits; a deadline
// is written on a task's first take, before it is ever compared.
// A waiting result blocks a new word; input ready only in idle with output free.
// ----------------------------------------------------------------------------
module priority_run_queue_with_affinity_unit
    import prq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    prq_in_if.sink    in_ch,
    prq_out_if.source out_ch,
    prq_cfg_if.sink   cfg_ch
);

    state_t state_reg, state_next;

    logic [15:0]            move_delay_reg;
    logic [TID_W-1:0]       head_reg [NUM_LEVELS];
    logic [TID_W-1:0]       tail_reg [NUM_LEVELS];
    logic [TID_W-1:0]       link_reg [NUM_TASKS];
    logic                   won_reg  [NUM_TASKS];
    logic [CORE_W-1:0]      wcore_reg[NUM_TASKS];
    logic [CORE_W-1:0]      lcore_reg[NUM_TASKS];
    logic [31:0]            dl_reg   [NUM_TASKS];
    logic [NUM_TASKS-1:0]   lvalid_reg, stop_reg, queued_reg;
    logic [NUM_LEVELS-1:0]  occ_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // latched request
    opcode_t           op_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [LVL_W-1:0]  pri_reg;
    logic              wv_reg, tick_reg, sv_reg;
    logic [CORE_W-1:0] wc_reg, core_reg;
    logic [31:0]       now_reg;

    // walk state
    logic [LVL_W-1:0]  lv_reg;
    logic              pass_reg, hp_reg;
    logic [TID_W-1:0]  t_reg, p_reg;
    logic [TID_W-1:0]  cur_reg;   // entry fields registered from the tables
    logic              al_reg, ok_reg, last_reg;
    logic [TID_W-1:0]  nxt_reg;
    logic [31:0]       sum_reg;

    logic              out_valid_reg, found_reg, pre_reg;
    logic [TID_W-1:0]  chosen_reg;

    logic in_fire, cfg_fire;
    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ch.ready = 1'b1;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg_ch.valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = (opcode_t'(in_ch.opcode) == OP_PICK) ?
                                                  ST_LVL : ST_DONE;
            ST_LVL:     state_next = occ_reg[lv_reg] ? ST_RD :
                                     (lv_reg == LVL_W'(NUM_LEVELS - 1)) ? ST_DONE : ST_LVL;
            ST_RD:      state_next = ST_EVAL;
            ST_EVAL:    state_next = (al_reg && (pass_reg || ok_reg)) ? ST_UNLINK :
                                     last_reg ? ((pass_reg && lv_reg ==
                                     LVL_W'(NUM_LEVELS - 1)) ? ST_DONE :
                                     pass_reg ? ST_LVL : ST_RD) : ST_RD;
            ST_UNLINK:  state_next = stop_reg[t_reg] ?
                                     ST_LVL : ST_TAKE;
            ST_TAKE:    state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            move_delay_reg <= MOVE_DELAY_RESET;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            lvalid_reg     <= '0;
            stop_reg       <= '0;
            queued_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
                move_delay_reg <= cfg_ch.data;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg   <= opcode_t'(in_ch.opcode);
                        tid_reg  <= in_ch.task_id;
                        pri_reg  <= in_ch.priority_req;
                        wv_reg   <= in_ch.wired_valid;
                        wc_reg   <= in_ch.wired_core;
                        core_reg <= in_ch.core_id;
                        now_reg  <= in_ch.now_ticks;
                        tick_reg <= in_ch.tick_event;
                        sv_reg   <= in_ch.stop_value;
                        lv_reg   <= '0;
                        found_reg  <= 1'b0;
                        chosen_reg <= '0;
                        pre_reg    <= 1'b0;
                    end
                end
                ST_LVL:
                begin
                    pass_reg <= 1'b0;
                    hp_reg   <= 1'b0;
                    t_reg    <= head_reg[lv_reg];
                    if (!occ_reg[lv_reg] && lv_reg != LVL_W'(NUM_LEVELS - 1))
                        lv_reg <= lv_reg + 1'b1;
                end
                ST_RD:
                begin
                    // one table read per step, results registered for the compare
                    al_reg   <= !won_reg[t_reg] || (wcore_reg[t_reg] == core_reg);
                    ok_reg   <= !lvalid_reg[t_reg] || (lcore_reg[t_reg] == core_reg) ||
                                (dl_reg[t_reg] < now_reg);
                    last_reg <= (tail_reg[lv_reg] == t_reg);
                    nxt_reg  <= link_reg[t_reg];
                    cur_reg  <= t_reg;
                end
                ST_EVAL:
                begin
                    if (!(al_reg && (pass_reg || ok_reg)))
                    begin
                        if (last_reg)
                        begin
                            t_reg  <= head_reg[lv_reg];
                            hp_reg <= 1'b0;
                            if (pass_reg && lv_reg != LVL_W'(NUM_LEVELS - 1))
                                lv_reg <= lv_reg + 1'b1;
                            pass_reg <= !pass_reg;
                        end
                        else
                        begin
                            hp_reg <= 1'b1;
                            p_reg  <= cur_reg;
                            t_reg  <= nxt_reg;
                        end
                    end
                end
                ST_UNLINK:
                begin
                    if (hp_reg)
                    begin
                        link_reg[p_reg] <= nxt_reg;
                        if (last_reg)
                            tail_reg[lv_reg] <= p_reg;
                    end
                    else if (last_reg)
                        occ_reg[lv_reg] <= 1'b0;
                    else
                        head_reg[lv_reg] <= nxt_reg;
                    queued_reg[t_reg] <= 1'b0;
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - 1'b1;
                    sum_reg <= now_reg + {16'd0, move_delay_reg};
                end
                ST_TAKE:
                begin
                    if (!lvalid_reg[t_reg] || lcore_reg[t_reg] != core_reg)
                        dl_reg[t_reg] <= sum_reg;
                    lvalid_reg[t_reg] <= 1'b1;
                    lcore_reg[t_reg]  <= core_reg;
                    found_reg  <= 1'b1;
                    chosen_reg <= t_reg;
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    unique case (op_reg)
                        OP_ENQ:
                        begin
                            if (!queued_reg[tid_reg])
                            begin
                                won_reg[tid_reg]   <= wv_reg;
                                wcore_reg[tid_reg] <= wc_reg;
                                if (occ_reg[pri_reg])
                                    link_reg[tail_reg[pri_reg]] <= tid_reg;
                                else
                                    head_reg[pri_reg] <= tid_reg;
                                tail_reg[pri_reg]   <= tid_reg;
                                queued_reg[tid_reg] <= 1'b1;
                                cnt_reg <= cnt_reg + 1'b1;
                                occ_reg[pri_reg] <= 1'b1;
                            end
                        end
                        OP_STOP: stop_reg[tid_reg] <= sv_reg;
                        OP_PRE:
                            pre_reg <= ((occ_reg & ((NUM_LEVELS'(1) << pri_reg) -
                                       NUM_LEVELS'(1))) != '0) ||
                                       (tick_reg && occ_reg[pri_reg]);
                        OP_PICK: ;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // result reflects state after item; for enqueue the count/bitmap update
    // lands with out_valid, so outputs are read from the registers directly
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.chosen_task  = chosen_reg;
    assign out_ch.preempt      = pre_reg;
    assign out_ch.ready_total  = cnt_reg;
    assign out_ch.level_bitmap = occ_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == ST_IDLE && !out_valid_reg))
        else $error("accept while busy");
    a_found_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.found) |-> (op_reg == OP_PICK))
        else $error("found on non-pick");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");

endmodule

/* sim/priority_run_queue_with_affinity_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_run_queue_with_affinity_unit_tb
// Drives enqueue, pick, set-stop and preempt-check words through the run
// queue, with random idling on both channels, and checks every result word
// against a behavioral copy of the queues, affinity and stop state.
// ----------------------------------------------------------------------------
module priority_run_queue_with_affinity_unit_tb;
    import prq_pkg::*;

    typedef struct packed {
        logic        found;
        logic [5:0]  chosen_task;
        logic        preempt;
        logic [6:0]  ready_total;
        logic [15:0] level_bitmap;
    } sched_res_t;

    logic clk;
    logic rst_n;

    prq_in_if  in_ch ();
    prq_out_if out_ch ();
    prq_cfg_if cfg_ch ();

    priority_run_queue_with_affinity_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // scheduler state mirror
    logic [15:0] delay_q;
    logic [5:0]  head_q [NUM_LEVELS];
    logic [5:0]  tail_q [NUM_LEVELS];
    logic [5:0]  link_q [NUM_TASKS];
    logic        wire_on_q [NUM_TASKS];
    logic [1:0]  wire_core_q [NUM_TASKS];
    logic        ran_q [NUM_TASKS];
    logic [1:0]  ran_core_q [NUM_TASKS];
    logic [31:0] deadline_q [NUM_TASKS];
    logic        stopped_q [NUM_TASKS];
    logic        queued_q [NUM_TASKS];
    logic [15:0] occ_q;
    logic [6:0]  count_q;

    sched_res_t pending_q [$];
    int         errors;
    int         n_words;
    int         n_found;
    int         n_preempt;
    bit         stall_on;
    logic [31:0] tick_now;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit may_run(input int t, input logic [1:0] c);
        return !wire_on_q[t] || wire_core_q[t] == c;
    endfunction

    function automatic sched_res_t schedule_word(input opcode_t op, input logic [5:0] tid,
        input logic [3:0] pri, input logic wv, input logic [1:0] wc, input logic [1:0] core,
        input logic [31:0] now, input logic tick, input logic sv);
        sched_res_t r;
        int lv;
        int t;
        int p;
        int hit;
        int hit_prev;
        logic [15:0] hi_mask;
        r = '0;
        case (op)
            OP_ENQ:
            begin
                if (!queued_q[tid])
                begin
                    wire_on_q[tid] = wv;
                    wire_core_q[tid] = wc;
                    if (occ_q[pri])
                        link_q[tail_q[pri]] = tid;
                    else
                        head_q[pri] = tid;
                    tail_q[pri] = tid;
                    queued_q[tid] = 1'b1;
                    count_q++;
                    occ_q[pri] = 1'b1;
                end
            end
            OP_PICK:
            begin
                lv = 0;
                while (lv < NUM_LEVELS)
                begin
                    hit = -1;
                    if (occ_q[lv])
                    begin
                        // first pass prefers cache-warm or movable tasks
                        for (int pass = 0; pass < 2 && hit < 0; pass++)
                        begin
                            t = head_q[lv];
                            p = -1;
                            for (int n = 0; n < NUM_TASKS; n++)
                            begin
                                if (may_run(t, core) && (pass == 1 || !ran_q[t] ||
                                    ran_core_q[t] == core || deadline_q[t] < now))
                                begin
                                    hit = t;
                                    hit_prev = p;
                                    break;
                                end
                                if (tail_q[lv] == t)
                                    break;
                                p = t;
                                t = link_q[t];
                            end
                        end
                    end
                    if (hit < 0)
                    begin
                        lv++;
                        continue;
                    end
                    if (hit_prev >= 0)
                    begin
                        link_q[hit_prev] = link_q[hit];
                        if (tail_q[lv] == hit)
                            tail_q[lv] = 6'(hit_prev);
                    end
                    else if (tail_q[lv] == hit)
                        occ_q[lv] = 1'b0;
                    else
                        head_q[lv] = link_q[hit];
                    queued_q[hit] = 1'b0;
                    if (count_q > 0)
                        count_q--;
                    if (stopped_q[hit])
                        continue;
                    if (!ran_q[hit] || ran_core_q[hit] != core)
                        deadline_q[hit] = now + {16'd0, delay_q};
                    ran_q[hit] = 1'b1;
                    ran_core_q[hit] = core;
                    r.found = 1'b1;
                    r.chosen_task = 6'(hit);
                    break;
                end
            end
            OP_STOP:
                stopped_q[tid] = sv;
            default:
            begin
                hi_mask = (16'd1 << pri) - 16'd1;
                r.preempt = (occ_q & hi_mask) != 0 || (tick && occ_q[pri]);
            end
        endcase
        r.ready_total = count_q;
        r.level_bitmap = occ_q;
        return r;
    endfunction

    // valid drops only when an idle burst follows
    task automatic random_gap();
        if (stall_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    task automatic send_word(input opcode_t op, input logic [5:0] tid, input logic [3:0] pri,
        input logic wv, input logic [1:0] wc, input logic [1:0] core, input logic [31:0] now,
        input logic tick, input logic sv);
        random_gap();
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.task_id      <= tid;
        in_ch.priority_req <= pri;
        in_ch.wired_valid  <= wv;
        in_ch.wired_core   <= wc;
        in_ch.core_id      <= core;
        in_ch.now_ticks    <= now;
        in_ch.tick_event   <= tick;
        in_ch.stop_value   <= sv;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_q.push_back(schedule_word(op, tid, pri, wv, wc, core, now, tick, sv));
        n_words++;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (400) @(negedge clk);
    endtask

    task automatic write_delay(input logic [15:0] d);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        delay_q = d;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_word(input int pick_bias);
        int sel;
        opcode_t op;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            op = OP_ENQ;
        else if (sel < 40 + pick_bias)
            op = OP_PICK;
        else if (sel < 85)
            op = OP_PRE;
        else
            op = OP_STOP;
        tick_now = tick_now + $urandom_range(0, 8);
        send_word(op, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)),
                  ($urandom_range(0, 15) == 0) ? $urandom : tick_now,
                  1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
    endtask

    task automatic test_directed();
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_PRE, 6'd0, 4'd15, 1'b0, 2'd0, 2'd0, 32'd0, 1'b1, 1'b0);
        send_word(OP_ENQ, 6'd63, 4'd15, 1'b1, 2'd3, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_ENQ, 6'd63, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_ENQ, 6'd0, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_ENQ, 6'd1, 4'd0, 1'b1, 2'd2, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_PRE, 6'd0, 4'd15, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_PRE, 6'd0, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_PRE, 6'd0, 4'd0, 1'b1, 2'd0, 2'd0, 32'd0, 1'b1, 1'b0);
        // wired task skipped by the wrong core, which stays queued at level 0
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd1, 32'd5, 1'b0, 1'b0);
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd3, 32'd5, 1'b0, 1'b0);
        // stopped task is dropped
        send_word(OP_STOP, 6'd1, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b1);
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd2, 32'd6, 1'b0, 1'b0);
        send_word(OP_STOP, 6'd1, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        // affinity: task 0 last on core 1, bound until deadline
        send_word(OP_ENQ, 6'd0, 4'd7, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_ENQ, 6'd2, 4'd7, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd2, 32'd7, 1'b0, 1'b0);
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd2, 32'hFFFF_FFF0, 1'b0, 1'b0);
        send_word(OP_PICK, 6'd0, 4'd0, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0, 1'b0);
    endtask

    task automatic test_random(input int n, input int pick_bias);
        for (int i = 0; i < n; i++)
            random_word(pick_bias);
    endtask

    task automatic test_config_sweep();
        write_delay(16'hFFFF);
        test_random(300, 30);
        write_delay(16'd0);
        test_random(300, 30);
        write_delay(16'($urandom));
        test_random(300, 25);
    endtask

    // result checker
    initial
    begin
        sched_res_t want;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                n_found += out_ch.found;
                n_preempt += out_ch.preempt;
                if (pending_q.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    want = pending_q.pop_front();
                    if (out_ch.found !== want.found)
                        report_mismatch("found", out_ch.found, want.found);
                    if (out_ch.chosen_task !== want.chosen_task)
                        report_mismatch("chosen_task", out_ch.chosen_task, want.chosen_task);
                    if (out_ch.preempt !== want.preempt)
                        report_mismatch("preempt", out_ch.preempt, want.preempt);
                    if (out_ch.ready_total !== want.ready_total)
                        report_mismatch("ready_total", out_ch.ready_total, want.ready_total);
                    if (out_ch.level_bitmap !== want.level_bitmap)
                        report_mismatch("level_bitmap", out_ch.level_bitmap,
                                        want.level_bitmap);
                end
            end
            @(negedge clk);
            out_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    initial
    begin
        #2000ms;
        $display("priority_run_queue_with_affinity_unit_tb failed");
        $finish;
    end

    initial
    begin
        errors = 0;
        n_words = 0;
        n_found = 0;
        n_preempt = 0;
        stall_on = 1'b1;
        tick_now = 32'd0;
        delay_q = MOVE_DELAY_RESET;
        occ_q = '0;
        count_q = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            ran_q[i] = 1'b0;
            ran_core_q[i] = '0;
            deadline_q[i] = '0;
            stopped_q[i] = 1'b0;
            queued_q[i] = 1'b0;
            link_q[i] = '0;
            wire_on_q[i] = 1'b0;
            wire_core_q[i] = '0;
        end
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ENQ;
        in_ch.task_id = '0;
        in_ch.priority_req = '0;
        in_ch.wired_valid = 1'b0;
        in_ch.wired_core = '0;
        in_ch.core_id = '0;
        in_ch.now_ticks = '0;
        in_ch.tick_event = 1'b0;
        in_ch.stop_value = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300, 30);
        test_config_sweep();
        write_delay(16'd10);
        stall_on = 1'b0;
        test_random(380, 30);
        drain();

        $display("words %0d, picks found %0d, preempts %0d, move_delay 0/10/65535 and random",
                 n_words, n_found, n_preempt);
        if (errors == 0 && pending_q.size() == 0)
            $display("priority_run_queue_with_affinity_unit_tb passed");
        else
            $display("priority_run_queue_with_affinity_unit_tb failed");
        $finish;
    end
endmodule

/* filelist.f */
src/prq_pkg.sv
src/prq_if.sv
src/priority_run_queue_with_affinity_unit.sv
sim/priority_run_queue_with_affinity_unit_tb.sv
